### rtl/core/dwr_pkg.sv
package dwr_pkg;

  // queue geometry
  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;

  // operation codes
  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_LIST       = 3'd4,
    FN_REVERSE    = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_ELEM  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // input item
  typedef struct packed {
    func_t              func;
    logic signed [31:0] value;
  } in_t;

  // result item
  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic               last;
  } out_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST,
    S_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic list_rd;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic list_go;
    logic list_last;
  } sts_t;

  // physical slot of a logical offset from the head, modulo depth
  function automatic idx_t slot_addr(idx_t head, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/dwr_ctrl.sv
module dwr_ctrl
  import dwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = sts.list_go ? S_LIST : S_IDLE;
      end
      S_LIST: begin
        if (sts.list_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    ctl     = '0;
    busy    = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
      end
      S_LIST: begin
        ctl.list_rd = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/core/dwr_datapath.sv
module dwr_datapath
  import dwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  input  in_t  cmd,
  output sts_t sts,
  output out_t result,
  output logic result_valid
);

  word_t mem [DEPTH];

  in_t   item_q;
  idx_t  head;
  idx_t  head_next;
  cnt_t  occ;
  cnt_t  occ_next;
  logic  rev;
  logic  rev_next;
  idx_t  list_idx;
  word_t rd_word;
  logic  rd_pend;
  logic  rd_last;
  out_t  res_next;
  logic  res_vld_next;

  logic  we;
  idx_t  wa;
  idx_t  ra;
  idx_t  head_dec;
  idx_t  head_inc;
  idx_t  list_off;
  logic  front_side;

  // ring neighbors of the head
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  // operation targets the physical front when its side differs from the flag
  assign front_side = ((item_q.func == FN_PUSH_FRONT) || (item_q.func == FN_POP_FRONT)) ^ rev;

  // listing walks from the head, or from the tail when reversed
  assign list_off = rev ? IDX_W'(occ - 1'b1 - CNT_W'(list_idx)) : list_idx;
  assign ra       = slot_addr(head, list_off);

  // status to controller
  assign sts.list_go   = (item_q.func == FN_LIST) && (occ != '0);
  assign sts.list_last = (CNT_W'(list_idx) == occ - 1'b1);

  // operation decode
  always_comb begin
    head_next    = head;
    occ_next     = occ;
    rev_next     = rev;
    we           = 1'b0;
    wa           = head;
    res_vld_next = 1'b0;
    res_next     = '{status: ST_DONE, element: '0, last: 1'b1};
    if (ctl.exec) begin
      case (item_q.func)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          res_vld_next = 1'b1;
          if (occ == CNT_W'(DEPTH)) begin
            res_next.status = ST_OVER;
          end else begin
            occ_next = occ + 1'b1;
            we       = 1'b1;
            if (front_side) begin
              head_next = head_dec;
              wa        = head_dec;
            end else begin
              wa = slot_addr(head, IDX_W'(occ));
            end
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          res_vld_next = 1'b1;
          if (occ == '0) begin
            res_next.status = ST_UNDER;
          end else begin
            occ_next = occ - 1'b1;
            if (front_side) begin
              head_next = head_inc;
            end
          end
        end
        FN_LIST: begin
          if (occ == '0) begin
            res_vld_next    = 1'b1;
            res_next.status = ST_EMPTY;
          end
        end
        FN_REVERSE: begin
          rev_next     = ~rev;
          res_vld_next = 1'b1;
        end
        default: begin
          res_vld_next = 1'b1;
        end
      endcase
    end else if (rd_pend) begin
      res_vld_next = 1'b1;
      res_next     = '{status: ST_ELEM, element: 32'(rd_word), last: rd_last};
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      occ          <= '0;
      rev          <= 1'b0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      head         <= head_next;
      occ          <= occ_next;
      rev          <= rev_next;
      rd_pend      <= ctl.list_rd;
      result_valid <= res_vld_next;
    end
  end

  // item capture, list walk and result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= cmd;
    end
    if (ctl.exec) begin
      list_idx <= '0;
    end else if (ctl.list_rd) begin
      list_idx <= list_idx + 1'b1;
    end
    rd_last <= sts.list_last;
    result  <= res_next;
  end

  // ring store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= WORD_WIDTH'(item_q.value);
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[ra];
  end

endmodule

### rtl/core/deque_with_reverse_top.sv
// push, pop, reverse and the empty list: result registered after the exec state; next start taken as it shows
// listing n elements: exec state, then the list state reads the store into a register, then the result
// register; then one element per cycle, busy drops with the last element shown
// rate is set by the ring store, with one read port and one write port, read once per cycle while listing
// synchronous reset empties the queue and clears the reverse flag; store contents persist
// results cannot be stalled: each stands on the ports for one cycle only
module deque_with_reverse_top
  import dwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  cmd,
  output logic busy,
  output out_t result,
  output logic result_valid
);

  ctl_t ctl;
  sts_t sts;

  // sequencing
  dwr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // ring store and pointers
  dwr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // only listed elements carry a value
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_ELEM) |-> (result.element == '0))
    else $error("nonzero element on status result");

  // list elements stream without gaps until the last one
  a_list_stream: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("gap in list output");

  // the final result of an item is never followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result right after last");
`endif

endmodule

### tb/tb.sv
module tb
  import dwr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // func codes the block treats as no operation
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  localparam int RANDOM_OPS  = 435;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int SETTLE      = 8;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  cmd   = '0;
  logic busy;
  out_t result;
  logic result_valid;

  deque_with_reverse_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  always #10 clk = ~clk;

  // ops waiting to be issued, and results the deque still owes
  in_t  op_backlog[$];
  out_t owed_results[$];

  // shadow deque in logical storage order, plus the direction flag
  word_t deque_words[$];
  bit    deque_flipped = 1'b0;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int no_gap_run     = 0;
  int planned_fill   = 0;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // expected results for one accepted op, applied to the shadow deque
  function automatic void apply_deque_op(in_t item);
    out_t res;
    int   n;
    int   idx;
    res.status  = ST_DONE;
    res.element = '0;
    res.last    = 1'b1;
    n = deque_words.size();
    case (item.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (n >= DEPTH) begin
          res.status = ST_OVER;
        end else if ((item.func == FN_PUSH_FRONT) != deque_flipped) begin
          deque_words.push_front(word_t'(item.value));
        end else begin
          deque_words.push_back(word_t'(item.value));
        end
        owed_results.push_back(res);
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (n == 0) begin
          res.status = ST_UNDER;
        end else if ((item.func == FN_POP_FRONT) != deque_flipped) begin
          void'(deque_words.pop_front());
        end else begin
          void'(deque_words.pop_back());
        end
        owed_results.push_back(res);
      end
      FN_LIST: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
          owed_results.push_back(res);
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = deque_flipped ? (n - 1 - i) : i;
            res.status  = ST_ELEM;
            res.element = deque_words[idx];
            res.last    = (i == n - 1);
            owed_results.push_back(res);
          end
        end
      end
      FN_REVERSE: begin
        deque_flipped = !deque_flipped;
        owed_results.push_back(res);
      end
      default: begin
        owed_results.push_back(res);
      end
    endcase
  endfunction

  // idle cycles before the next op, with runs of back-to-back ops
  function automatic int draw_gap();
    if (no_gap_run > 0) begin
      no_gap_run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      no_gap_run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // stimulus planning: queue an op and track the expected fill level
  task automatic plan_op(logic [2:0] f, logic signed [31:0] v);
    in_t item;
    item.func  = func_t'(f);
    item.value = v;
    op_backlog.push_back(item);
    if ((f == FN_PUSH_FRONT || f == FN_PUSH_BACK) && planned_fill < DEPTH) begin
      planned_fill++;
    end else if ((f == FN_POP_FRONT || f == FN_POP_BACK) && planned_fill > 0) begin
      planned_fill--;
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return FN_PUSH_FRONT;
    if (r < 44) return FN_PUSH_BACK;
    if (r < 59) return FN_POP_FRONT;
    if (r < 74) return FN_POP_BACK;
    if (r < 86) return FN_LIST;
    if (r < 95) return FN_REVERSE;
    if (r < 98) return FN_SPARE_6;
    return FN_SPARE_7;
  endfunction

  // push until full, bump into the limit, then show the contents
  task automatic plan_fill();
    while (planned_fill < DEPTH) begin
      plan_op($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, rand_word());
    end
    repeat ($urandom_range(1, 3)) begin
      plan_op($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, rand_word());
    end
    plan_op(FN_LIST, rand_word());
  endtask

  // driver: hold start until the op is taken, then idle for a random gap
  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        apply_deque_op(cmd);
        gap_left   = draw_gap();
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_backlog.size() > 0) begin
          cmd        <= op_backlog.pop_front();
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // monitor: every strobed result against the oldest owed one
  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid) begin
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d element %0d last %0b",
                                result.status, result.element, result.last));
      end else begin
        want = owed_results.pop_front();
        if (result.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
        end
        if (result.element !== want.element) begin
          flag_mismatch($sformatf("element %0d, want %0d", result.element, want.element));
        end
        if (result.last !== want.last) begin
          flag_mismatch($sformatf("last %0b, want %0b", result.last, want.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int directed_ops;
    int kind;
    int waited;

    // directed: empty corner cases, extremes, both directions
    plan_op(FN_POP_FRONT, 32'h0);
    plan_op(FN_POP_BACK, 32'h0);
    plan_op(FN_LIST, 32'h0);
    plan_op(FN_REVERSE, 32'h0);
    plan_op(FN_PUSH_FRONT, 32'h7fff_ffff);
    plan_op(FN_REVERSE, 32'h0);
    plan_op(FN_PUSH_BACK, 32'h8000_0000);
    plan_op(FN_PUSH_FRONT, 32'h0000_0000);
    plan_op(FN_PUSH_BACK, 32'hffff_ffff);
    plan_op(FN_LIST, 32'h0);
    plan_op(FN_REVERSE, 32'h0);
    plan_op(FN_LIST, 32'h0);
    plan_op(FN_PUSH_FRONT, 32'h5555_5555);
    plan_op(FN_PUSH_BACK, 32'haaaa_aaaa);
    plan_op(FN_LIST, 32'h0);
    plan_op(FN_POP_FRONT, 32'h0);
    plan_op(FN_POP_BACK, 32'h0);
    plan_op(FN_REVERSE, 32'h0);
    plan_op(FN_LIST, 32'h0);
    plan_op(FN_SPARE_6, 32'hffff_ffff);
    plan_op(FN_SPARE_7, 32'h1234_5678);
    plan_op(FN_POP_FRONT, 32'h0);
    plan_op(FN_POP_BACK, 32'h0);
    plan_op(FN_POP_FRONT, 32'h0);
    plan_op(FN_LIST, 32'h0);
    directed_ops = op_backlog.size();

    // random: episodes of mixed ops, drains, fills and direction flips
    plan_fill();
    while (op_backlog.size() - directed_ops < RANDOM_OPS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        repeat ($urandom_range(1, 8)) plan_op(rand_func(), rand_word());
      end else if (kind == 6) begin
        while (planned_fill > 0) begin
          plan_op($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, rand_word());
        end
        repeat ($urandom_range(1, 2)) begin
          plan_op($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, rand_word());
        end
        plan_op(FN_LIST, rand_word());
      end else if (kind == 7) begin
        if (planned_fill >= 32 && $urandom_range(0, 2) == 0) begin
          plan_fill();
        end else begin
          repeat ($urandom_range(8, 16)) begin
            plan_op($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, rand_word());
          end
        end
      end else begin
        plan_op(FN_REVERSE, rand_word());
        repeat ($urandom_range(1, 4)) plan_op(rand_func(), rand_word());
        plan_op(FN_LIST, rand_word());
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for the last op to be taken and every result to come back
    while (op_backlog.size() > 0 || start) @(posedge clk);
    waited = 0;
    while (owed_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (owed_results.size() > 0) begin
      flag_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
